// ----- src/tmr_pkg.sv -----
package tmr_pkg;

   localparam int TILE_COUNT_DEF   = 256;
   localparam int FRAME_WIDTH_DEF  = 320;
   localparam int FRAME_HEIGHT_DEF = 200;

   // Largest map the block draws, in tiles, before the frame size limits it.
   localparam int MAX_MAP_COLS = 40;
   localparam int MAX_MAP_ROWS = 25;

   localparam int TILE_SIZE = 8;
   localparam int ROW_IDX_W = 3;
   localparam logic [ROW_IDX_W-1:0] LAST_ROW = 3'd7;

   localparam int COL_W = 6;
   localparam int ROWS_W = 5;
   localparam int ADDR_W = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = 1'b1;
   localparam logic [COL_W-1:0]  MAP_WIDTH_RESET  = 6'd40;
   localparam logic [ROWS_W-1:0] MAP_HEIGHT_RESET = 5'd25;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef struct packed {
      logic                 load_we;
      logic                 draw_start;
      logic                 rd_issue;
      logic [ROW_IDX_W-1:0] rd_row;
      logic                 out_load;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] row_address;
      logic [7:0][1:0]   pixels;
      logic              last_row;
   } row_type;

endpackage

// ----- src/tmr_if.sv -----
interface tmr_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  tile_index;
   logic        frame_start;
   logic [11:0] load_address;
   logic [7:0]  load_byte;

   modport source (output valid, operation, tile_index, frame_start, load_address,
                   load_byte, input ready);
   modport sink (input valid, operation, tile_index, frame_start, load_address,
                 load_byte, output ready);
endinterface

interface tmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] row_address;
   logic [1:0]  pixel_0;
   logic [1:0]  pixel_1;
   logic [1:0]  pixel_2;
   logic [1:0]  pixel_3;
   logic [1:0]  pixel_4;
   logic [1:0]  pixel_5;
   logic [1:0]  pixel_6;
   logic [1:0]  pixel_7;
   logic        last_row;

   modport source (output valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
                   pixel_4, pixel_5, pixel_6, pixel_7, last_row, input ready);
   modport sink (input valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
                 pixel_4, pixel_5, pixel_6, pixel_7, last_row, output ready);
endinterface

// ----- src/tmr_ctrl.sv -----
module tmr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_operation,
   input  logic              rsp_ready,
   output logic              req_ready,
   output logic              rsp_valid,
   output tmr_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic [tmr_pkg::ROW_IDX_W-1:0] row_ff, row_in;
   logic rd_v_ff, rd_v_in;
   logic out_v_ff, out_v_in;

   logic pop, move, rd_free, issue, last_issue, accept;

   always_comb begin
      pop        = out_v_ff && rsp_ready;
      move       = rd_v_ff && (!out_v_ff || pop);
      rd_free    = !rd_v_ff || move;
      issue      = (state_ff == ST_RUN) && rd_free;
      last_issue = issue && (row_ff == tmr_pkg::LAST_ROW);
      // The next item is taken in the cycle that reads the last tile row.
      req_ready  = (state_ff == ST_IDLE) || last_issue;
      accept     = req_valid && req_ready;

      cmd.load_we    = accept && (req_operation == tmr_pkg::OP_LOAD);
      cmd.draw_start = accept && (req_operation == tmr_pkg::OP_DRAW);
      cmd.rd_issue   = issue;
      cmd.rd_row     = row_ff;
      cmd.out_load   = move;

      state_in = state_ff;
      row_in   = row_ff;
      if (cmd.draw_start) begin
         state_in = ST_RUN;
         row_in   = '0;
      end else if (last_issue) begin
         state_in = ST_IDLE;
      end else if (issue) begin
         row_in = row_ff + 1'b1;
      end

      rd_v_in  = issue ? 1'b1 : (move ? 1'b0 : rd_v_ff);
      out_v_in = move ? 1'b1 : (pop ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         rd_v_ff  <= rd_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid = out_v_ff;

endmodule

// ----- src/tmr_datapath.sv -----
module tmr_datapath #(
   parameter int TILE_COUNT   = tmr_pkg::TILE_COUNT_DEF,
   parameter int FRAME_WIDTH  = tmr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tmr_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tmr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tmr_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [7:0]                       req_tile_index,
   input  logic                             req_frame_start,
   input  logic [11:0]                      req_load_address,
   input  logic [7:0]                       req_load_byte,
   input  tmr_pkg::cmd_type                 cmd,
   output tmr_pkg::row_type                 out_row
);

   localparam int COLS_FRAME = FRAME_WIDTH / tmr_pkg::TILE_SIZE;
   localparam int ROWS_FRAME = FRAME_HEIGHT / tmr_pkg::TILE_SIZE;
   localparam int MAX_COLS = (COLS_FRAME < tmr_pkg::MAX_MAP_COLS) ? COLS_FRAME
                                                                   : tmr_pkg::MAX_MAP_COLS;
   localparam int MAX_ROWS = (ROWS_FRAME < tmr_pkg::MAX_MAP_ROWS) ? ROWS_FRAME
                                                                   : tmr_pkg::MAX_MAP_ROWS;
   localparam int TW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
   localparam int WORDS = TILE_COUNT * tmr_pkg::TILE_SIZE;
   localparam int WA = $clog2(WORDS);
   localparam int STORE_BYTES = TILE_COUNT * 16;
   localparam int ROW_STRIDE = tmr_pkg::TILE_SIZE * FRAME_WIDTH;

   localparam int CW = tmr_pkg::COL_W;
   localparam int RW = tmr_pkg::ROWS_W;
   localparam int AW = tmr_pkg::ADDR_W;

   logic [CW-1:0] map_width_ff;
   logic [RW-1:0] map_height_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [TW-1:0] tile_ff;
   logic [AW-1:0] row_addr_ff;

   logic [CW-1:0] cols_eff;
   logic [RW:0]   rows_eff;
   logic [CW-1:0] col_a, col_n;
   logic [RW:0]   row_a, row_c, row_n;
   logic [AW-1:0] base_in;
   logic [7:0]    tile_mod;

   // Config writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= tmr_pkg::MAP_WIDTH_RESET;
         map_height_ff <= tmr_pkg::MAP_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tmr_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_data;
            tmr_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_data[RW-1:0];
            default: ;
         endcase
      end
   end

   // Cursor placement for a draw: wrap before use, then advance.
   always_comb begin
      if (map_width_ff == '0) begin
         cols_eff = CW'(1);
      end else if (map_width_ff > CW'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = map_width_ff;
      end
      if (map_height_ff == '0) begin
         rows_eff = (RW+1)'(1);
      end else if (map_height_ff > RW'(MAX_ROWS)) begin
         rows_eff = (RW+1)'(MAX_ROWS);
      end else begin
         rows_eff = {1'b0, map_height_ff};
      end

      col_a = req_frame_start ? '0 : col_ff;
      row_a = req_frame_start ? '0 : {1'b0, row_ff};
      if (col_a >= cols_eff) begin
         col_a = '0;
         row_a = row_a + 1'b1;
      end
      row_c = (row_a >= rows_eff) ? '0 : row_a;

      col_n = col_a + 1'b1;
      row_n = row_c;
      if (col_n >= cols_eff) begin
         col_n = '0;
         row_n = row_c + 1'b1;
         if (row_n >= rows_eff) begin
            row_n = '0;
         end
      end

      base_in = AW'(row_c * ROW_STRIDE) + AW'({col_a, 3'b000});

      // The tile number folds into the tile count through a constant table.
      tile_mod = req_tile_index;
      for (int t = 0; t < 256; t++) begin
         if (req_tile_index == 8'(t)) begin
            tile_mod = 8'(t % TILE_COUNT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.draw_start) begin
         col_ff <= col_n;
         row_ff <= row_n[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         tile_ff     <= TW'(tile_mod);
         row_addr_ff <= base_in;
      end else if (cmd.rd_issue) begin
         row_addr_ff <= row_addr_ff + AW'(FRAME_WIDTH);
      end
   end

   // Tile memory: even bytes and odd bytes of each tile row in two lanes.
   logic [7:0] even_mem [WORDS];
   logic [7:0] odd_mem  [WORDS];
   logic [7:0] even_q, odd_q;
   logic [WA-1:0] wr_word, rd_word;
   logic in_range;

   assign in_range = ({1'b0, req_load_address} < 13'(STORE_BYTES));
   assign wr_word  = req_load_address[WA:1];
   assign rd_word  = WA'({tile_ff, cmd.rd_row});

   always_ff @(posedge clock) begin
      if (cmd.load_we && in_range && !req_load_address[0]) begin
         even_mem[wr_word] <= req_load_byte;
      end
      if (cmd.rd_issue) begin
         even_q <= even_mem[rd_word];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && in_range && req_load_address[0]) begin
         odd_mem[wr_word] <= req_load_byte;
      end
      if (cmd.rd_issue) begin
         odd_q <= odd_mem[rd_word];
      end
   end

   // Read stage sideband, captured with the memory read.
   logic [AW-1:0] rd_addr_ff;
   logic rd_last_ff;
   tmr_pkg::row_type out_ff, out_in;

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_addr_ff <= row_addr_ff;
         rd_last_ff <= (cmd.rd_row == tmr_pkg::LAST_ROW);
      end
   end

   always_comb begin
      out_in.row_address = rd_addr_ff;
      out_in.last_row    = rd_last_ff;
      for (int i = 0; i < 4; i++) begin
         out_in.pixels[i]     = even_q[7-2*i -: 2];
         out_in.pixels[i + 4] = odd_q[7-2*i -: 2];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign out_row = out_ff;

endmodule

// ----- src/tile_map_renderer_2bpp.sv -----
// Tile map renderer, 8x8 tiles at 2 bits per pixel.
// The req_bus channel carries two kinds of beat. A load beat writes one byte of
// tile memory (16 bytes per tile, two per tile row, leftmost pixel in the top
// bit pair). A draw beat names a tile for the cell under the cursor; the block
// answers with eight rsp_bus beats, top row first, each with the framebuffer
// index of the row's first pixel and its eight color indices. The cursor then
// steps right and wraps to the next map row and back to the top.
// The csr_ port sets map width and height in tiles; write it only while idle.
// A draw reads the tile memory once per row, and the next beat
// is taken in the cycle of the last row read, so a new draw overlaps the end
// of the previous one. The draw beat starts the read sequence; each row passes
// through the read stage into the output register. A load beat returns nothing.
// A stalled receiver holds rows in the output register and one read stage;
// reads pause until space frees, so nothing is dropped.
// Synchronous reset homes the cursor and restores the map size to 40 by 25.
// Tile memory is not cleared; draw only tiles that were loaded.
module tile_map_renderer_2bpp #(
   parameter int TILE_COUNT   = tmr_pkg::TILE_COUNT_DEF,
   parameter int FRAME_WIDTH  = tmr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tmr_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmr_pkg::CSR_DATA_W-1:0]  csr_data,
   tmr_req_if.sink                         req_bus,
   tmr_rsp_if.source                       rsp_bus
);

   tmr_pkg::cmd_type cmd;
   tmr_pkg::row_type out_row;

   tmr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .rsp_ready     (rsp_bus.ready),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .cmd           (cmd)
   );

   tmr_datapath #(
      .TILE_COUNT   (TILE_COUNT),
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_tile_index   (req_bus.tile_index),
      .req_frame_start  (req_bus.frame_start),
      .req_load_address (req_bus.load_address),
      .req_load_byte    (req_bus.load_byte),
      .cmd              (cmd),
      .out_row          (out_row)
   );

   assign rsp_bus.row_address = out_row.row_address;
   assign rsp_bus.pixel_0     = out_row.pixels[0];
   assign rsp_bus.pixel_1     = out_row.pixels[1];
   assign rsp_bus.pixel_2     = out_row.pixels[2];
   assign rsp_bus.pixel_3     = out_row.pixels[3];
   assign rsp_bus.pixel_4     = out_row.pixels[4];
   assign rsp_bus.pixel_5     = out_row.pixels[5];
   assign rsp_bus.pixel_6     = out_row.pixels[6];
   assign rsp_bus.pixel_7     = out_row.pixels[7];
   assign rsp_bus.last_row    = out_row.last_row;

   // A new beat is only taken when no tile rows are left to read.
   a_accept_between_tiles: assert property (@(posedge clock) disable iff (reset)
      (cmd.draw_start || cmd.load_we) |-> (!cmd.rd_issue || cmd.rd_row == tmr_pkg::LAST_ROW))
      else $error("beat accepted in the middle of a tile");

   // Rows of a tile are read in order, one after another.
   a_rows_in_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_issue && cmd.rd_row != tmr_pkg::LAST_ROW)
      |=> (cmd.rd_row == $past(cmd.rd_row) + 3'd1))
      else $error("tile row sequence broken");

   // Reading stops after the last row unless another draw began.
   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_issue && cmd.rd_row == tmr_pkg::LAST_ROW && !cmd.draw_start)
      |=> !cmd.rd_issue)
      else $error("tile memory read without a draw");

endmodule
